FILE: sv/blvm_pkg.sv
package blvm_pkg;

  localparam int unsigned SampleW = 15;
  localparam int unsigned AlphaW  = 16;
  localparam int unsigned LevelW  = 15;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned FracW   = 16;
  localparam int unsigned FiltW   = SampleW + FracW;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  typedef logic [FiltW-1:0] filt_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAlpha    = 3'd0,
    CfgCutoff   = 3'd1,
    CfgRecover  = 3'd2,
    CfgDebounce = 3'd3
  } cfg_idx_e;

  localparam logic [AlphaW-1:0] AlphaReset    = 16'd1285;
  localparam logic [LevelW-1:0] CutoffReset   = 15'd8400;
  localparam logic [LevelW-1:0] RecoverReset  = 15'd8800;
  localparam logic [TicksW-1:0] DebounceReset = 16'd100;

  localparam logic [TicksW-1:0] CountMax = {TicksW{1'b1}};

endpackage

FILE: sv/blvm_filter.sv
module blvm_filter (
  input  blvm_pkg::filt_t                 filt_i,
  input  logic [blvm_pkg::SampleW-1:0]    sample_i,
  input  logic [blvm_pkg::AlphaW-1:0]     alpha_i,
  output blvm_pkg::filt_t                 filt_o
);

  localparam int unsigned ProdW = blvm_pkg::AlphaW + blvm_pkg::FiltW;

  blvm_pkg::filt_t   target;
  blvm_pkg::filt_t   mag;
  blvm_pkg::filt_t   step;
  logic              rising;
  logic [ProdW-1:0]  prod;
  logic [ProdW-1:0]  prod_rnd;

  assign target = {sample_i, {blvm_pkg::FracW{1'b0}}};
  assign rising = (target >= filt_i);
  assign mag    = rising ? (target - filt_i) : (filt_i - target);

  // Rounded to nearest, ties away from zero, applied to the magnitude.
  assign prod     = ProdW'(alpha_i) * ProdW'(mag);
  assign prod_rnd = prod + ProdW'(1 << (blvm_pkg::FracW - 1));
  assign step     = prod_rnd[ProdW-1:blvm_pkg::FracW];

  assign filt_o = rising ? (filt_i + step) : (filt_i - step);

endmodule

FILE: sv/battery_low_voltage_monitor.sv
// A result passes through the input register and then the result register.
// Throughput: one sample per cycle while out_stall_i is low; the input register
// and the result register let a new sample enter while a finished result waits
// to be taken. The filter step is one multiply-add between the two registers.
// Reset clears the filter, the low flag and the debounce run; the configuration
// registers return to their default values. No clearing pass is needed.
module battery_low_voltage_monitor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [blvm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [blvm_pkg::CfgW-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [blvm_pkg::SampleW-1:0]     raw_voltage_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [blvm_pkg::SampleW-1:0]     smoothed_voltage_o,
  output logic                             low_battery_o,
  output logic                             low_changed_o
);

  logic [blvm_pkg::AlphaW-1:0] alpha_q;
  logic [blvm_pkg::LevelW-1:0] cutoff_q;
  logic [blvm_pkg::LevelW-1:0] recover_q;
  logic [blvm_pkg::TicksW-1:0] debounce_q;

  logic                        in_valid_q, in_valid_d;
  logic [blvm_pkg::SampleW-1:0] raw_q;
  logic                        in_take;
  logic                        advance;

  blvm_pkg::filt_t             filt_q, filt_d;
  blvm_pkg::filt_t             filt_step;
  logic                        primed_q;
  logic                        low_flag_q, low_flag_d;
  logic                        below_seen_q, below_seen_d;
  logic [blvm_pkg::TicksW-1:0] below_count_q, below_count_d;
  logic                        is_below, is_above;

  logic                        out_valid_q, out_valid_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= blvm_pkg::AlphaReset;
      cutoff_q   <= blvm_pkg::CutoffReset;
      recover_q  <= blvm_pkg::RecoverReset;
      debounce_q <= blvm_pkg::DebounceReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        blvm_pkg::CfgAlpha:    alpha_q    <= cfg_wdata_i[blvm_pkg::AlphaW-1:0];
        blvm_pkg::CfgCutoff:   cutoff_q   <= cfg_wdata_i[blvm_pkg::LevelW-1:0];
        blvm_pkg::CfgRecover:  recover_q  <= cfg_wdata_i[blvm_pkg::LevelW-1:0];
        blvm_pkg::CfgDebounce: debounce_q <= cfg_wdata_i[blvm_pkg::TicksW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake between the input register and the result register.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  blvm_filter u_filter (
    .filt_i   (filt_q),
    .sample_i (raw_q),
    .alpha_i  (alpha_q),
    .filt_o   (filt_step)
  );

  assign is_below = (filt_step < {cutoff_q, {blvm_pkg::FracW{1'b0}}});
  assign is_above = (filt_step > {recover_q, {blvm_pkg::FracW{1'b0}}});

  always_comb begin
    filt_d        = filt_step;
    low_flag_d    = low_flag_q;
    below_seen_d  = below_seen_q;
    below_count_d = below_count_q;
    if (!primed_q) begin
      // The first sample loads the filter and leaves the flag logic alone.
      filt_d = {raw_q, {blvm_pkg::FracW{1'b0}}};
    end else if (!low_flag_q) begin
      if (is_below) begin
        if (!below_seen_q) begin
          below_seen_d  = 1'b1;
          below_count_d = '0;
        end else if (below_count_q != blvm_pkg::CountMax) begin
          below_count_d = below_count_q + 1'b1;
        end
        if (below_count_d >= debounce_q) begin
          low_flag_d = 1'b1;
        end
      end else begin
        below_seen_d  = 1'b0;
        below_count_d = '0;
      end
    end else if (is_above) begin
      low_flag_d    = 1'b0;
      below_seen_d  = 1'b0;
      below_count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      filt_q        <= '0;
      primed_q      <= 1'b0;
      low_flag_q    <= 1'b0;
      below_seen_q  <= 1'b0;
      below_count_q <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        filt_q        <= filt_d;
        primed_q      <= 1'b1;
        low_flag_q    <= low_flag_d;
        below_seen_q  <= below_seen_d;
        below_count_q <= below_count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      raw_q <= raw_voltage_i;
    end
    if (advance) begin
      smoothed_voltage_o <= filt_d[blvm_pkg::FiltW-1:blvm_pkg::FracW];
      low_battery_o      <= low_flag_d;
      low_changed_o      <= (low_flag_d != low_flag_q);
    end
  end

  assign out_valid_o = out_valid_q;

  // The low flag can only be raised once the filter has been loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !primed_q |-> !low_flag_q)
    else $error("low flag set before the filter was primed");

  // A result leaving the compute stage shows the flag state it committed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (low_battery_o == low_flag_q))
    else $error("result flag differs from the stored low flag");

  // A change is reported only when the flag really moved.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (low_changed_o == (low_flag_q != $past(low_flag_q))))
    else $error("low_changed does not match the flag transition");

endmodule

FILE: tb/sv/tb_battery_low_voltage_monitor.sv
`timescale 1ns / 1ps

module tb_battery_low_voltage_monitor;
  import blvm_pkg::*;

  localparam int unsigned CycleLimit = 600000;

  typedef struct packed {
    logic [SampleW-1:0] smoothed;
    logic               low;
    logic               changed;
  } reading_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgAlpha;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [SampleW-1:0] raw_voltage_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [SampleW-1:0] smoothed_voltage_o;
  logic               low_battery_o;
  logic               low_changed_o;

  battery_low_voltage_monitor u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .raw_voltage_i      (raw_voltage_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .smoothed_voltage_o (smoothed_voltage_o),
    .low_battery_o      (low_battery_o),
    .low_changed_o      (low_changed_o)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the configuration and of the monitor state.
  logic [AlphaW-1:0] alpha_q    = AlphaReset;
  logic [LevelW-1:0] cutoff_q   = CutoffReset;
  logic [LevelW-1:0] recover_q  = RecoverReset;
  logic [TicksW-1:0] debounce_q = DebounceReset;
  logic [31:0]       filt_q     = '0;
  logic              filt_primed = 1'b0;
  logic              flag_low    = 1'b0;
  logic              run_active  = 1'b0;
  logic [TicksW-1:0] run_count   = '0;

  reading_t    pending_readings[$];
  reading_t    want;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_max_gap = 17;
  int unsigned rx_max_stall = 17;
  int unsigned stall_left = 0;

  function automatic reading_t predict_reading(logic [SampleW-1:0] raw);
    logic [31:0] target;
    logic [63:0] step;
    logic        was_low;
    reading_t    r;
    target  = {1'b0, raw, 16'h0000};
    was_low = flag_low;
    if (!filt_primed) begin
      filt_q      = target;
      filt_primed = 1'b1;
    end else begin
      // Step is rounded to nearest, ties away from zero, in either direction.
      if (target >= filt_q) begin
        step   = (64'(alpha_q) * 64'(target - filt_q) + 64'h8000) >> 16;
        filt_q = filt_q + step[31:0];
      end else begin
        step   = (64'(alpha_q) * 64'(filt_q - target) + 64'h8000) >> 16;
        filt_q = filt_q - step[31:0];
      end
      if (!flag_low) begin
        if (filt_q < {1'b0, cutoff_q, 16'h0000}) begin
          if (!run_active) begin
            run_active = 1'b1;
            run_count  = '0;
          end else if (run_count != CountMax) begin
            run_count = run_count + 1'b1;
          end
          if (run_count >= debounce_q) flag_low = 1'b1;
        end else begin
          run_active = 1'b0;
          run_count  = '0;
        end
      end else if (filt_q > {1'b0, recover_q, 16'h0000}) begin
        flag_low   = 1'b0;
        run_active = 1'b0;
        run_count  = '0;
      end
    end
    r.smoothed = filt_q[30:16];
    r.low      = flag_low;
    r.changed  = (flag_low != was_low);
    return r;
  endfunction

  // All tasks below start and end at a falling edge.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgAlpha:    alpha_q    = data;
      CfgCutoff:   cutoff_q   = data[LevelW-1:0];
      CfgRecover:  recover_q  = data[LevelW-1:0];
      CfgDebounce: debounce_q = data;
      default: ;
    endcase
  endtask

  task automatic send_sample(logic [SampleW-1:0] raw);
    int unsigned gap;
    gap = $urandom_range(tx_max_gap, 0);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    raw_voltage_i = raw;
    do @(posedge clk_i); while (in_stall_o);
    pending_readings.push_back(predict_reading(raw));
    @(negedge clk_i);
  endtask

  task automatic wait_readings_done();
    in_valid_i = 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic test_priming();
    // A priming sample below the cutoff must not touch the flag logic.
    send_sample(15'd0);
    send_sample(15'd0);
    send_sample(15'd1);
    wait_readings_done();
  endtask

  task automatic test_zero_debounce();
    write_reg(CfgAlpha, 16'hFFFF);
    write_reg(CfgDebounce, 16'd0);
    send_sample(15'd0);
    send_sample(15'h7FFF);
    send_sample(15'h7FFF);
    send_sample(15'd0);
    send_sample(15'd0);
    wait_readings_done();
  endtask

  task automatic test_frozen_filter();
    write_reg(CfgAlpha, 16'd0);
    send_sample(15'h7FFF);
    send_sample(15'h5555);
    send_sample(15'h2AAA);
    wait_readings_done();
  endtask

  task automatic test_threshold_extremes();
    write_reg(CfgAlpha, 16'hFFFF);
    // Upper bit of the write data lies beyond the level width.
    write_reg(CfgCutoff, 16'hFFFF);
    write_reg(CfgRecover, 16'hFFFF);
    send_sample(15'h7FFF);
    wait_readings_done();
    write_reg(CfgRecover, 16'd0);
    write_reg(CfgCutoff, 16'd0);
    send_sample(15'd1);
    send_sample(15'd0);
    wait_readings_done();
    // Recover level below the cutoff makes the flag toggle on every sample.
    write_reg(CfgCutoff, 16'd20000);
    write_reg(CfgRecover, 16'd10000);
    send_sample(15'd15000);
    send_sample(15'd15000);
    send_sample(15'd15000);
    wait_readings_done();
  endtask

  task automatic test_unused_indexes();
    for (int i = int'(CfgDebounce) + 1; i < 2 ** CfgIdxW; i++) begin
      write_reg(CfgIdxW'(i), CfgW'($urandom_range(65535, 0)));
    end
    send_sample(15'd16384);
    send_sample(15'd15000);
    wait_readings_done();
  endtask

  task automatic test_debounce_run();
    write_reg(CfgCutoff, 16'd8400);
    write_reg(CfgRecover, 16'd8800);
    write_reg(CfgDebounce, 16'd3);
    send_sample(15'd20000);
    repeat (3) send_sample(15'd0);
    send_sample(15'd20000);
    repeat (4) send_sample(15'd0);
    wait_readings_done();
  endtask

  task automatic test_debounce_limit();
    tx_max_gap   = 0;
    rx_max_stall = 0;
    write_reg(CfgAlpha, 16'hFFFF);
    write_reg(CfgCutoff, 16'd0);
    write_reg(CfgRecover, 16'd0);
    send_sample(15'h7FFF);
    wait_readings_done();
    // With the longest debounce the flag stays clear through a long run below the cutoff.
    write_reg(CfgCutoff, 16'h7FFF);
    write_reg(CfgRecover, 16'h7FFF);
    write_reg(CfgDebounce, 16'hFFFF);
    repeat (40) send_sample(SampleW'($urandom_range(32000, 0)));
    wait_readings_done();
    tx_max_gap   = 17;
    rx_max_stall = 17;
  endtask

  task automatic test_random_phases();
    int unsigned cut;
    int unsigned rec;
    int unsigned level;
    int unsigned run_len;
    int unsigned sent;
    int          v;
    for (int phase = 0; phase < 7; phase++) begin
      wait_readings_done();
      cut = $urandom_range(16000, 4000);
      rec = (phase == 3) ? cut - $urandom_range(3000, 1) : cut + $urandom_range(2500, 0);
      write_reg(CfgAlpha, (phase == 0) ? 16'hFFFF :
                          (phase == 5) ? CfgW'($urandom_range(600, 1)) :
                                         CfgW'($urandom_range(65535, 4096)));
      write_reg(CfgCutoff, CfgW'(cut));
      write_reg(CfgRecover, CfgW'(rec));
      write_reg(CfgDebounce, (phase == 1) ? 16'd0 : CfgW'($urandom_range(6, 0)));
      tx_max_gap   = (phase == 2 || phase == 6) ? 0 : 17;
      rx_max_stall = (phase == 2 || phase == 4) ? 0 : 17;
      sent = 0;
      while (sent < 150) begin
        if ($urandom_range(9, 0) < 2) begin
          send_sample(SampleW'($urandom_range(32767, 0)));
          sent++;
        end else begin
          // A run of noisy samples around a level on one side of the thresholds.
          if ($urandom_range(1, 0) == 1) level = $urandom_range(cut - 1, 0);
          else level = $urandom_range(32767, ((rec > cut) ? rec : cut) + 1);
          run_len = $urandom_range(int'(debounce_q) + 4, 1);
          repeat (run_len) begin
            v = int'(level) + int'($urandom_range(300, 0)) - 150;
            if (v < 0) v = 0;
            if (v > 32767) v = 32767;
            send_sample(SampleW'(v));
            sent++;
          end
        end
        if ($urandom_range(39, 0) == 0) wait_readings_done();
      end
    end
    wait_readings_done();
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d readings outstanding", $time, pending_readings.size());
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected reading smoothed=%0d low=%0b changed=%0b", $time,
                 smoothed_voltage_o, low_battery_o, low_changed_o);
        mismatch_count++;
      end else begin
        want = pending_readings.pop_front();
        if (smoothed_voltage_o !== want.smoothed) begin
          $display("%0t: smoothed_voltage expected %0d actual %0d", $time,
                   want.smoothed, smoothed_voltage_o);
          mismatch_count++;
        end
        if (low_battery_o !== want.low) begin
          $display("%0t: low_battery expected %0b actual %0b", $time, want.low, low_battery_o);
          mismatch_count++;
        end
        if (low_changed_o !== want.changed) begin
          $display("%0t: low_changed expected %0b actual %0b", $time,
                   want.changed, low_changed_o);
          mismatch_count++;
        end
      end
      stall_left = $urandom_range(rx_max_stall, 0);
    end
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_priming();
    test_zero_debounce();
    test_frozen_filter();
    test_threshold_extremes();
    test_unused_indexes();
    test_debounce_run();
    test_debounce_limit();
    test_random_phases();
    wait_readings_done();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
